[hw/rtl/f2fp10_pkg.sv]
// Shared widths and encodings for the float32 to FP10 (e5m4) converter.
// No dependencies; used by the channel interfaces and the top level.

package f2fp10_pkg;

   // Payload widths
   localparam int FLOAT_WIDTH = 32;
   localparam int CODE_WIDTH  = 10;

   // Single-precision field layout
   localparam int EXP32_WIDTH  = 8;
   localparam int MANT32_WIDTH = 23;
   localparam int SIG32_WIDTH  = MANT32_WIDTH + 1;

   // Biased single-precision exponent thresholds (bias 127)
   localparam logic [EXP32_WIDTH-1:0] EXP32_ALL_ONES   = 8'hFF;
   localparam logic [EXP32_WIDTH-1:0] EXP32_MAX_FINITE = 8'd142;  // unbiased 15
   localparam logic [EXP32_WIDTH-1:0] EXP32_MIN_NORMAL = 8'd113;  // unbiased -14
   localparam logic [EXP32_WIDTH-1:0] EXP32_MIN_KEEP   = 8'd108;  // unbiased -19

   // Rebias 127 -> 15, and the subnormal shift base (shift = 132 - exp)
   localparam logic [EXP32_WIDTH-1:0] EXP_REBIAS    = 8'd112;
   localparam logic [EXP32_WIDTH-1:0] SUB_SHIFT_TOP = 8'd132;

   // Magnitude codes (exponent and fraction, sign excluded)
   localparam logic [CODE_WIDTH-2:0] MAG_INF  = 9'h1F0;
   localparam logic [CODE_WIDTH-2:0] MAG_NAN  = 9'h1F1;
   localparam logic [CODE_WIDTH-2:0] MAG_ZERO = 9'h000;

endpackage

[hw/rtl/f2fp10_req_if.sv]
// Request channel: one float32 bit pattern per item, valid/ready handshake.
// Depends on f2fp10_pkg for the payload width.

interface f2fp10_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [f2fp10_pkg::FLOAT_WIDTH-1:0]   float_bits;

   modport source (output valid, output float_bits, input ready);
   modport sink   (input valid, input float_bits, output ready);
endinterface

[hw/rtl/f2fp10_rsp_if.sv]
// Response channel: one FP10 code per item, valid/ready handshake.
// Depends on f2fp10_pkg for the payload width.

interface f2fp10_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [f2fp10_pkg::CODE_WIDTH-1:0]    fp10_code;

   modport source (output valid, output fp10_code, input ready);
   modport sink   (input valid, input fp10_code, output ready);
endinterface

[hw/rtl/float32_to_fp10_convert_unit.sv]
// A request passes through the input register, the convert logic and the result
// register before its response is valid.
// Throughput: one item per cycle while the response channel is ready; the input
// register refills while a finished result waits in the result register.
// Reset (synchronous, active high) empties both stages; payload is not cleared.
// Depends on f2fp10_pkg, f2fp10_req_if and f2fp10_rsp_if.

module float32_to_fp10_convert_unit (
   input  logic          clock,
   input  logic          reset,
   f2fp10_req_if.sink    req_chan,
   f2fp10_rsp_if.source  rsp_chan
);

   // Stage registers
   logic                                    s1_valid_ff, s1_valid_in;
   logic [f2fp10_pkg::FLOAT_WIDTH-1:0]      s1_bits_ff, s1_bits_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [f2fp10_pkg::CODE_WIDTH-1:0]       rsp_code_ff, rsp_code_in;

   logic s1_advance;
   logic req_take;

   // Decoded operand fields
   logic                                    sign;
   logic [f2fp10_pkg::EXP32_WIDTH-1:0]      exp32;
   logic [f2fp10_pkg::MANT32_WIDTH-1:0]     mant;
   logic                                    is_nan;
   logic                                    is_big;
   logic                                    is_tiny;
   logic                                    is_normal;

   // Normal path
   logic [f2fp10_pkg::EXP32_WIDTH-1:0]      norm_exp_full;
   logic                                    norm_round;
   logic [f2fp10_pkg::CODE_WIDTH-2:0]       norm_mag;

   // Subnormal path
   logic [f2fp10_pkg::SIG32_WIDTH-1:0]      sig;
   logic [f2fp10_pkg::EXP32_WIDTH-1:0]      sh_full;
   logic [4:0]                              sh;
   logic [4:0]                              sh_m1;
   logic [f2fp10_pkg::SIG32_WIDTH-1:0]      sub_shifted;
   logic [f2fp10_pkg::SIG32_WIDTH-1:0]      sub_rshift;
   logic [f2fp10_pkg::SIG32_WIDTH-1:0]      sub_mask;
   logic [3:0]                              sub_frac;
   logic                                    sub_round;
   logic [4:0]                              sub_sum;
   logic [f2fp10_pkg::CODE_WIDTH-2:0]       sub_mag;

   logic [f2fp10_pkg::CODE_WIDTH-2:0]       mag;

   // Handshake: stage 1 moves on when the result register is free or draining
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Split the operand
   assign sign  = s1_bits_ff[31];
   assign exp32 = s1_bits_ff[30:23];
   assign mant  = s1_bits_ff[22:0];

   assign is_nan    = (exp32 == f2fp10_pkg::EXP32_ALL_ONES) && (mant != '0);
   assign is_big    = exp32 > f2fp10_pkg::EXP32_MAX_FINITE;
   assign is_tiny   = exp32 < f2fp10_pkg::EXP32_MIN_KEEP;
   assign is_normal = exp32 >= f2fp10_pkg::EXP32_MIN_NORMAL;

   // Normal range: rebias, round to nearest even; a fraction carry bumps the exponent
   always_comb begin
      norm_exp_full = exp32 - f2fp10_pkg::EXP_REBIAS;
      norm_round    = mant[18] && ((|mant[17:0]) || mant[19]);
      norm_mag      = {norm_exp_full[4:0], mant[22:19]}
                      + {{(f2fp10_pkg::CODE_WIDTH-2){1'b0}}, norm_round};
   end

   // Subnormal range: shift significand to units of 2^-18 and round; 16 lands on min normal
   always_comb begin
      sig         = {1'b1, mant};
      sh_full     = f2fp10_pkg::SUB_SHIFT_TOP - exp32;
      sh          = sh_full[4:0];
      sh_m1       = sh - 5'd1;
      sub_shifted = sig >> sh;
      sub_rshift  = sig >> sh_m1;
      sub_mask    = ({{(f2fp10_pkg::SIG32_WIDTH-1){1'b0}}, 1'b1} << sh_m1)
                    - {{(f2fp10_pkg::SIG32_WIDTH-1){1'b0}}, 1'b1};
      sub_frac    = sub_shifted[3:0];
      sub_round   = sub_rshift[0] && ((|(sig & sub_mask)) || sub_frac[0]);
      sub_sum     = {1'b0, sub_frac} + {4'd0, sub_round};
      sub_mag     = {4'd0, sub_sum};
   end

   // Pick the magnitude by range
   always_comb begin
      if (is_nan) begin
         mag = f2fp10_pkg::MAG_NAN;
      end else if (is_big) begin
         mag = f2fp10_pkg::MAG_INF;
      end else if (is_tiny) begin
         mag = f2fp10_pkg::MAG_ZERO;
      end else if (is_normal) begin
         mag = norm_mag;
      end else begin
         mag = sub_mag;
      end
   end

   // Next-state values
   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
      s1_bits_in   = req_take ? req_chan.float_bits : s1_bits_ff;
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_chan.ready);
      rsp_code_in  = s1_advance ? {sign, mag} : rsp_code_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_bits_ff  <= s1_bits_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fp10_code = rsp_code_ff;

   // Both stages are empty right after reset
   assert property (@(posedge clock) $past(reset) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // An item that leaves stage 1 shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced item did not reach result register");

   // A full pipeline with a stalled result must refuse new items
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("accepting into a blocked pipeline");

   // A NaN operand always leaves as exponent 31 with fraction 1
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && is_nan |=> rsp_code_ff[f2fp10_pkg::CODE_WIDTH-2:0] == f2fp10_pkg::MAG_NAN)
      else $error("NaN not encoded as canonical NaN");

   // The sign passes through unchanged
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_code_ff[f2fp10_pkg::CODE_WIDTH-1] == $past(s1_bits_ff[31]))
      else $error("sign bit altered");

endmodule
